### design/rqir_pkg.sv
// Package for the ring queue with indexed removal.
// Holds sizes, command codes and the request, result and cell control types.
// No dependencies.
`timescale 1ns / 1ps

package rqir_pkg;

    // Storage sizes
    localparam int SLOT_COUNT = 16;
    localparam int ENTRY_BITS = 32;
    localparam int CELL_COUNT = SLOT_COUNT - 1;

    // Field widths
    localparam int CMD_W  = 3;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 4;
    localparam int RING_W = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

    // Ring size limits
    localparam logic [RING_W-1:0] RING_MIN = 5'd2;
    localparam logic [RING_W-1:0] RING_MAX = RING_W'(SLOT_COUNT);

    // Request payload
    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [IDX_W-1:0]      entry_index;
        logic [ENTRY_BITS-1:0] write_value;
    } t_req;

    // Result payload
    typedef struct packed {
        logic                  ok;
        logic [ENTRY_BITS-1:0] read_value;
        logic [CNT_W-1:0]      entry_count;
        logic                  is_empty;
        logic                  is_full;
    } t_res;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic             load;      // store write data at position == count
        logic             shift;     // take neighbor data at position >= from_idx
        logic [IDX_W-1:0] from_idx;
        logic [CNT_W-1:0] count;
    } t_cell_ctl;

endpackage

### design/rqir_cell.sv
// One storage cell of the queue row; holds the entry at a fixed position.
// Depends on rqir_pkg for widths and the cell control struct.
`timescale 1ns / 1ps

module rqir_cell (
    input  logic                           i_clk,
    input  logic [rqir_pkg::CNT_W-1:0]     i_pos,
    input  rqir_pkg::t_cell_ctl            i_ctl,
    input  logic [rqir_pkg::ENTRY_BITS-1:0] i_write,
    input  logic [rqir_pkg::ENTRY_BITS-1:0] i_next,
    output logic [rqir_pkg::ENTRY_BITS-1:0] o_data
);

    logic [rqir_pkg::ENTRY_BITS-1:0] r_data;
    logic [rqir_pkg::ENTRY_BITS-1:0] n_data;

    // Load at the tail, or pull from the younger neighbor when shifting
    always_comb begin
        n_data = r_data;
        if (i_ctl.load && (i_pos == i_ctl.count)) begin
            n_data = i_write;
        end else if (i_ctl.shift && (i_pos >= rqir_pkg::CNT_W'(i_ctl.from_idx))) begin
            n_data = i_next;
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### design/ring_queue_with_indexed_removal.sv
// Top level of the ring queue with indexed removal.
// Depends on rqir_pkg and rqir_cell.
`timescale 1ns / 1ps

// A FIFO of up to ring_size - 1 words kept in order, oldest first, in a row
// of cells. Busy stays low, so a request can be started in every cycle, and
// its result appears on o_res with o_res_valid high for exactly one cycle, in
// the cycle after the request is taken. The receiver cannot stall; it must
// take each result in that cycle. Pop and remove close the gap as every cell
// from the removed position onward loads its younger neighbor. A ring size
// write (always ready) empties the queue; values below 2 act as 2, above 16
// act as 16.
module ring_queue_with_indexed_removal (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  rqir_pkg::t_req              i_req,
    output logic                        o_res_valid,
    output rqir_pkg::t_res              o_res,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rqir_pkg::RING_W-1:0] i_cfg_data
);

    logic [rqir_pkg::CNT_W-1:0]      r_count;
    logic [rqir_pkg::CNT_W-1:0]      n_count;
    logic [rqir_pkg::RING_W-1:0]     r_ring;
    logic [rqir_pkg::RING_W-1:0]     n_ring;
    logic                            r_res_valid;
    rqir_pkg::t_res                  r_res;
    rqir_pkg::t_res                  n_res;
    rqir_pkg::t_cell_ctl             w_ctl;
    logic                            w_accept;
    logic                            w_ok;
    logic                            w_idx_ok;
    logic                            w_full;
    logic [rqir_pkg::IDX_W-1:0]      w_rd_addr;
    logic [rqir_pkg::ENTRY_BITS-1:0] w_cell [rqir_pkg::CELL_COUNT];
    logic [rqir_pkg::ENTRY_BITS-1:0] w_next [rqir_pkg::CELL_COUNT];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // Queue status before the request
    assign w_full   = ({1'b0, r_count} == (r_ring - 5'd1));
    assign w_idx_ok = (rqir_pkg::CNT_W'(i_req.entry_index) < r_count);

    // Request decode
    always_comb begin
        w_ok         = 1'b0;
        n_count      = r_count;
        w_ctl.load   = 1'b0;
        w_ctl.shift  = 1'b0;
        w_ctl.from_idx = i_req.entry_index;
        w_ctl.count  = r_count;
        w_rd_addr    = i_req.entry_index;
        case (i_req.command)
            rqir_pkg::CMD_CLEAR: begin
                w_ok    = 1'b1;
                n_count = '0;
            end
            rqir_pkg::CMD_PUSH: begin
                if (!w_full) begin
                    w_ok       = 1'b1;
                    w_ctl.load = 1'b1;
                    n_count    = r_count + 4'd1;
                end
            end
            rqir_pkg::CMD_POP: begin
                w_rd_addr      = '0;
                w_ctl.from_idx = '0;
                if (r_count != '0) begin
                    w_ok        = 1'b1;
                    w_ctl.shift = 1'b1;
                    n_count     = r_count - 4'd1;
                end
            end
            rqir_pkg::CMD_READ: begin
                w_ok = w_idx_ok;
            end
            rqir_pkg::CMD_REMOVE: begin
                if (w_idx_ok) begin
                    w_ok        = 1'b1;
                    w_ctl.shift = 1'b1;
                    n_count     = r_count - 4'd1;
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
        if (!w_accept) begin
            w_ctl.load  = 1'b0;
            w_ctl.shift = 1'b0;
        end
    end

    // Result of the request
    always_comb begin
        n_res.ok          = w_ok;
        n_res.read_value  = '0;
        if (w_ok && (i_req.command != rqir_pkg::CMD_CLEAR)
                 && (i_req.command != rqir_pkg::CMD_PUSH)) begin
            n_res.read_value = w_cell[w_rd_addr];
        end
        n_res.entry_count = n_count;
        n_res.is_empty    = (n_count == '0);
        n_res.is_full     = ({1'b0, n_count} == (r_ring - 5'd1));
    end

    // Ring size write, clamped to the legal range
    always_comb begin
        n_ring = r_ring;
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_data < rqir_pkg::RING_MIN) begin
                n_ring = rqir_pkg::RING_MIN;
            end else if (i_cfg_data > rqir_pkg::RING_MAX) begin
                n_ring = rqir_pkg::RING_MAX;
            end else begin
                n_ring = i_cfg_data;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ring      <= rqir_pkg::RING_MAX;
            r_res_valid <= 1'b0;
        end else begin
            r_ring      <= n_ring;
            r_res_valid <= w_accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= '0;
            end else if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Row of cells, each but the last fed by its younger neighbor
    genvar gi;
    generate
        for (gi = 0; gi < rqir_pkg::CELL_COUNT; gi++) begin : g_cell
            if (gi == rqir_pkg::CELL_COUNT - 1) begin : g_last
                assign w_next[gi] = w_cell[gi];
            end else begin : g_mid
                assign w_next[gi] = w_cell[gi+1];
            end
            rqir_cell u_cell (
                .i_clk   (i_clk),
                .i_pos   (rqir_pkg::CNT_W'(gi)),
                .i_ctl   (w_ctl),
                .i_write (i_req.write_value),
                .i_next  (w_next[gi]),
                .o_data  (w_cell[gi])
            );
        end
    endgenerate

`ifndef SYNTHESIS
    // Held entries never exceed the capacity of the ring
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} <= (r_ring - 5'd1)))
        else $error("entry count beyond ring capacity");

    // Every taken request yields one result strobe in the next cycle
    a_res_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_res_valid)
        else $error("result strobe missing after request");

    // A pop from a non-empty queue drops the count by one
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_valid && (i_req.command == rqir_pkg::CMD_POP)
         && (r_count != '0)) |=> (r_count == $past(r_count) - 4'd1))
        else $error("pop did not decrement count");
`endif

endmodule

### sim/tb.sv
// Testbench for ring_queue_with_indexed_removal: a directed script, then random phases.
// Every result is checked against an in-bench queue predictor or a fixed answer from the script.
// Depends on rqir_pkg and the ring_queue_with_indexed_removal RTL.
`timescale 1ns / 1ps

module tb;

    // Unknown command codes and run limits
    localparam logic [rqir_pkg::CMD_W-1:0] CMD_BAD_LO  = 3'd5;
    localparam logic [rqir_pkg::CMD_W-1:0] CMD_BAD_MID = 3'd6;
    localparam logic [rqir_pkg::CMD_W-1:0] CMD_BAD_HI  = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int REPORT_MAX = 10;

    typedef enum logic {ROW_REQUEST, ROW_RING_WRITE} t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic [rqir_pkg::RING_W-1:0] ring_val;
        rqir_pkg::t_req              req;
        bit                          fixed;   // expected result typed into the row
        rqir_pkg::t_res              res;
    } t_script_row;

    typedef struct {
        bit             fixed;
        rqir_pkg::t_res res;
    } t_fixed_answer;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    rqir_pkg::t_req              req = '0;
    logic                        res_valid;
    rqir_pkg::t_res              res;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [rqir_pkg::RING_W-1:0] cfg_data = '0;

    // Predictor state
    logic [rqir_pkg::ENTRY_BITS-1:0] ring_slots [rqir_pkg::SLOT_COUNT];
    int ring_head;
    int ring_tail;
    int ring_len;

    rqir_pkg::t_res expected_results [$];
    t_fixed_answer  row_answers [$];
    t_script_row    script_rows [$];
    int             mismatches = 0;
    int             stall_cycles = 0;
    int             drv_ring = rqir_pkg::SLOT_COUNT;

    ring_queue_with_indexed_removal dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ring size as the block applies it
    function automatic int ring_of(input logic [rqir_pkg::RING_W-1:0] v);
        if (v < rqir_pkg::RING_MIN) return int'(rqir_pkg::RING_MIN);
        if (v > rqir_pkg::RING_MAX) return int'(rqir_pkg::RING_MAX);
        return int'(v);
    endfunction

    // One queue operation: updates the predictor state, returns the result
    function automatic rqir_pkg::t_res predict_queue_op(input rqir_pkg::t_req r);
        rqir_pkg::t_res out;
        int             held;
        int             pos;
        int             nx;
        out = '0;
        held = (ring_tail + ring_len - ring_head) % ring_len;
        case (r.command)
            rqir_pkg::CMD_CLEAR: begin
                ring_head = 0;
                ring_tail = 0;
                out.ok = 1'b1;
            end
            rqir_pkg::CMD_PUSH: begin
                if ((ring_tail + 1) % ring_len != ring_head) begin
                    ring_slots[ring_tail] = r.write_value;
                    ring_tail = (ring_tail + 1) % ring_len;
                    out.ok = 1'b1;
                end
            end
            rqir_pkg::CMD_POP: begin
                if (held != 0) begin
                    out.read_value = ring_slots[ring_head];
                    ring_head = (ring_head + 1) % ring_len;
                    out.ok = 1'b1;
                end
            end
            rqir_pkg::CMD_READ: begin
                if (int'(r.entry_index) < held) begin
                    pos = (ring_head + int'(r.entry_index)) % ring_len;
                    out.read_value = ring_slots[pos];
                    out.ok = 1'b1;
                end
            end
            rqir_pkg::CMD_REMOVE: begin
                if (int'(r.entry_index) < held) begin
                    pos = (ring_head + int'(r.entry_index)) % ring_len;
                    out.read_value = ring_slots[pos];
                    // close the gap toward the front
                    while (pos != ring_tail) begin
                        nx = (pos + 1) % ring_len;
                        ring_slots[pos] = ring_slots[nx];
                        pos = nx;
                    end
                    ring_tail = (ring_tail + ring_len - 1) % ring_len;
                    out.ok = 1'b1;
                end
            end
            default: ;
        endcase
        held = (ring_tail + ring_len - ring_head) % ring_len;
        out.entry_count = rqir_pkg::CNT_W'(held);
        out.is_empty = (held == 0);
        out.is_full = ((ring_tail + 1) % ring_len == ring_head);
        return out;
    endfunction

    // Track accepted requests and ring writes, check every result
    always @(posedge clk) begin
        rqir_pkg::t_res want;
        t_fixed_answer  ans;
        if (!rst_n) begin
            foreach (ring_slots[i]) ring_slots[i] = '0;
            ring_head = 0;
            ring_tail = 0;
            ring_len = ring_of(rqir_pkg::RING_MAX);
        end else begin
            if (cfg_valid && cfg_ready) begin
                ring_len = ring_of(cfg_data);
                ring_head = 0;
                ring_tail = 0;
            end
            if (start && !busy) begin
                want = predict_queue_op(req);
                if (row_answers.size() != 0) begin
                    ans = row_answers.pop_front();
                    if (ans.fixed) want = ans.res;
                end
                expected_results.push_back(want);
            end
            if (res_valid) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result with nothing expected: %p", $realtime, res);
                end else begin
                    want = expected_results.pop_front();
                    if (res.ok !== want.ok || res.read_value !== want.read_value ||
                        res.entry_count !== want.entry_count ||
                        res.is_empty !== want.is_empty || res.is_full !== want.is_full) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, want, res);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no request or ring write taken
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic rqir_pkg::t_req mk_req(input logic [rqir_pkg::CMD_W-1:0] cmd,
                                              input int idx,
                                              input logic [rqir_pkg::ENTRY_BITS-1:0] val);
        rqir_pkg::t_req r;
        r.command = cmd;
        r.entry_index = rqir_pkg::IDX_W'(idx);
        r.write_value = val;
        return r;
    endfunction

    function automatic rqir_pkg::t_res mk_res(input bit ok,
                                              input logic [rqir_pkg::ENTRY_BITS-1:0] rv,
                                              input int cnt, input bit empty,
                                              input bit full);
        rqir_pkg::t_res r;
        r.ok = ok;
        r.read_value = rv;
        r.entry_count = rqir_pkg::CNT_W'(cnt);
        r.is_empty = empty;
        r.is_full = full;
        return r;
    endfunction

    // Random request, mostly well formed for the current ring size
    function automatic rqir_pkg::t_req random_request();
        rqir_pkg::t_req r;
        int             roll;
        roll = $urandom_range(99);
        r.write_value = $urandom;
        if ($urandom_range(9) == 0)
            r.entry_index = rqir_pkg::IDX_W'($urandom_range(15));
        else
            r.entry_index = rqir_pkg::IDX_W'($urandom_range(drv_ring - 2));
        if (roll < 32)      r.command = rqir_pkg::CMD_PUSH;
        else if (roll < 48) r.command = rqir_pkg::CMD_POP;
        else if (roll < 70) r.command = rqir_pkg::CMD_READ;
        else if (roll < 91) r.command = rqir_pkg::CMD_REMOVE;
        else if (roll < 95) r.command = rqir_pkg::CMD_CLEAR;
        else r.command = rqir_pkg::CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        return r;
    endfunction

    // Wait for every outstanding result, then a little longer
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_ring_size(input logic [rqir_pkg::RING_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        drv_ring = ring_of(v);
    endtask

    // Present one request after a random gap; returns once it is taken
    task automatic issue_request(input rqir_pkg::t_req r, input bit fixed,
                                 input rqir_pkg::t_res fixed_res, input int idle_pct);
        t_fixed_answer ans;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        ans.fixed = fixed;
        ans.res = fixed_res;
        row_answers.push_back(ans);
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    initial begin
        logic [rqir_pkg::RING_W-1:0] phase_rings [PHASES];
        int                          phase_idle [PHASES];

        phase_rings = '{5'd16, 5'd2, 5'd3, 5'd5, 5'd8, 5'd0, 5'd1, 5'd17, 5'd31, 5'd16};
        phase_idle  = '{0, 53, 6, 53, 0, 6, 53, 0, 53, 6};
        phase_rings[PHASES-1] = rqir_pkg::RING_W'($urandom_range(31));

        // Directed script: empty-queue errors, unknown commands, extremes, tiny ring
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_POP, 0, '0), 1'b1,
                                mk_res(0, '0, 0, 1, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_READ, 0, '0), 1'b1,
                                mk_res(0, '0, 0, 1, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_REMOVE, 15, '1), 1'b1,
                                mk_res(0, '0, 0, 1, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(CMD_BAD_LO, 15, '1), 1'b1,
                                mk_res(0, '0, 0, 1, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(CMD_BAD_HI, 0, '0), 1'b1,
                                mk_res(0, '0, 0, 1, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_CLEAR, 0, '0), 1'b1,
                                mk_res(1, '0, 0, 1, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_PUSH, 0, '1), 1'b1,
                                mk_res(1, '0, 1, 0, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_PUSH, 15, '0), 1'b1,
                                mk_res(1, '0, 2, 0, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_READ, 0, '0), 1'b1,
                                mk_res(1, '1, 2, 0, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_READ, 1, '0), 1'b1,
                                mk_res(1, '0, 2, 0, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_READ, 2, '0), 1'b1,
                                mk_res(0, '0, 2, 0, 0)});
        script_rows.push_back('{ROW_REQUEST, '0,
                                mk_req(rqir_pkg::CMD_PUSH, 0, 32'h1234_5678), 1'b0, '0});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_REMOVE, 1, '0),
                                1'b0, '0});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_READ, 1, '0),
                                1'b0, '0});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(CMD_BAD_MID, 1, '1), 1'b1,
                                mk_res(0, '0, 2, 0, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_POP, 0, '0), 1'b1,
                                mk_res(1, '1, 1, 0, 0)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_CLEAR, 7, '1), 1'b1,
                                mk_res(1, '0, 0, 1, 0)});
        // ring size below the minimum acts as two: one usable entry
        script_rows.push_back('{ROW_RING_WRITE, 5'd0, '0, 1'b0, '0});
        script_rows.push_back('{ROW_REQUEST, '0,
                                mk_req(rqir_pkg::CMD_PUSH, 0, 32'hA5A5_A5A5), 1'b1,
                                mk_res(1, '0, 1, 0, 1)});
        script_rows.push_back('{ROW_REQUEST, '0,
                                mk_req(rqir_pkg::CMD_PUSH, 0, 32'h5A5A_5A5A), 1'b1,
                                mk_res(0, '0, 1, 0, 1)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_READ, 1, '0), 1'b1,
                                mk_res(0, '0, 1, 0, 1)});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_REMOVE, 0, '0), 1'b1,
                                mk_res(1, 32'hA5A5_A5A5, 0, 1, 0)});
        // ring size above the maximum acts as sixteen
        script_rows.push_back('{ROW_RING_WRITE, 5'd31, '0, 1'b0, '0});
        script_rows.push_back('{ROW_REQUEST, '0,
                                mk_req(rqir_pkg::CMD_PUSH, 0, 32'h8000_0001), 1'b0, '0});
        script_rows.push_back('{ROW_REQUEST, '0, mk_req(rqir_pkg::CMD_REMOVE, 0, '0),
                                1'b0, '0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_rows[i]) begin
            if (script_rows[i].kind == ROW_RING_WRITE)
                write_ring_size(script_rows[i].ring_val);
            else
                issue_request(script_rows[i].req, script_rows[i].fixed,
                              script_rows[i].res, 0);
        end

        // Random phases, each at its own ring size and gap rate
        for (int ph = 0; ph < PHASES; ph++) begin
            write_ring_size(phase_rings[ph]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                issue_request(random_request(), 1'b0, '0, phase_idle[ph]);
                // occasional full pause mid-phase
                if ($urandom_range(199) == 0) drain_results();
            end
        end

        drain_results();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
design/rqir_pkg.sv
design/rqir_cell.sv
design/ring_queue_with_indexed_removal.sv
sim/tb.sv
